// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the lexer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SCL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define SCL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/scl_pkg.sv =====
// Types, codes and character constants of the shell command lexer.
package scl_pkg;

	// Default depth of the queue between classifier and result sequencer
	localparam int SCL_QUEUE_DEPTH = 4;

	// Characters with a role in the grammar
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_BAR   = 8'h7C;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;

	// Result kinds
	typedef enum logic [2:0] {
		KIND_BYTE   = 3'd0,
		KIND_TOKEND = 3'd1,
		KIND_LINE   = 3'd2,
		KIND_ERROR  = 3'd3,
		KIND_INEND  = 3'd4
	} kind_t;

	// Lexer modes
	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_WORD  = 3'd1,
		MODE_GT    = 3'd2,
		MODE_AMP   = 3'd3,
		MODE_BAR   = 3'd4,
		MODE_QUOTE = 3'd5
	} mode_t;

	// Input transaction payload
	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_input;
	} in_item_t;

	// Result transaction payload
	typedef struct packed {
		kind_t      kind;
		logic [7:0] token_byte;
		logic       last;
	} out_item_t;

	// All results caused by one character, as queued between front and back
	typedef struct packed {
		logic [1:0]      cnt;
		kind_t [2:0]     kinds;
		logic [7:0]      tok_byte;
	} bundle_t;

	// Queue status seen by the front and back parts
	typedef struct packed {
		logic full;
		logic nonempty;
	} q_status_t;

endpackage

// ===== rtl/core/scl_chan_if.sv =====
// Valid/ready channel interface with a typed payload.
interface scl_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/scl_front.sv =====
// Front part: accepts characters, tracks lexer mode, builds result bundles.
`include "assert_macros.svh"
module scl_front import scl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	scl_chan_if.sink   char_ch,
	input  q_status_t  q_stat,
	output logic       push,
	output bundle_t    push_data
);

	mode_t   mode_q;
	mode_t   mode_nxt;
	bundle_t bnd;
	logic    accept;
	logic    ch_word;
	logic    pre_end;
	logic    do_idle;
	logic [7:0] ch;
	logic    eoi;
	logic [7:0] dbl;
	logic [1:0] n;
	kind_t   k [3];

	assign ch  = char_ch.data.char_in;
	assign eoi = char_ch.data.end_of_input;

	assign char_ch.ready = !q_stat.full;
	assign accept        = char_ch.valid && char_ch.ready;

	// Word characters: anything but blanks, newline and operator characters
	assign ch_word = (ch != CH_NL) && (ch != CH_SPACE) && (ch != CH_TAB) &&
		(ch != CH_BAR) && (ch != CH_AMP) && (ch != CH_SEMI) && (ch != CH_LT) &&
		(ch != CH_GT) && (ch != CH_LPAR) && (ch != CH_RPAR);

	// Doubling character of the pending operator
	always_comb begin
		unique case (mode_q)
			MODE_GT:  dbl = CH_GT;
			MODE_AMP: dbl = CH_AMP;
			default:  dbl = CH_BAR;
		endcase
	end

	// Classification: results of this character and next mode
	always_comb begin
		mode_nxt = mode_q;
		pre_end  = 1'b0;
		do_idle  = 1'b0;
		n        = 2'd0;
		k[0]     = KIND_BYTE;
		k[1]     = KIND_BYTE;
		k[2]     = KIND_BYTE;

		unique case (mode_q)
			MODE_WORD: begin
				if (!eoi && ch_word) begin
					k[0] = KIND_BYTE;
					n    = 2'd1;
				end else begin
					pre_end = 1'b1;
					do_idle = 1'b1;
				end
			end
			MODE_GT, MODE_AMP, MODE_BAR: begin
				if (!eoi && ch == dbl) begin
					k[0]     = KIND_BYTE;
					k[1]     = KIND_TOKEND;
					n        = 2'd2;
					mode_nxt = MODE_IDLE;
				end else begin
					pre_end = 1'b1;
					do_idle = 1'b1;
				end
			end
			MODE_QUOTE: begin
				priority if (eoi) begin
					k[0]     = KIND_ERROR;
					k[1]     = KIND_INEND;
					n        = 2'd2;
					mode_nxt = MODE_IDLE;
				end else if (ch == CH_NL) begin
					k[0]     = KIND_ERROR;
					k[1]     = KIND_LINE;
					n        = 2'd2;
					mode_nxt = MODE_IDLE;
				end else if (ch == CH_QUOTE) begin
					k[0]     = KIND_TOKEND;
					n        = 2'd1;
					mode_nxt = MODE_IDLE;
				end else begin
					k[0] = KIND_BYTE;
					n    = 2'd1;
				end
			end
			default: begin
				do_idle = 1'b1;
			end
		endcase

		// Token end ahead of re-handling the character between tokens
		if (pre_end) begin
			k[0] = KIND_TOKEND;
			n    = 2'd1;
		end

		// Between-tokens handling appends after any token end
		if (do_idle) begin
			mode_nxt = MODE_IDLE;
			if (eoi) begin
				k[n] = KIND_INEND;
				n    = n + 2'd1;
			end else if (ch == CH_SPACE || ch == CH_TAB) begin
				mode_nxt = MODE_IDLE;
			end else if (ch == CH_NL) begin
				k[n] = KIND_LINE;
				n    = n + 2'd1;
			end else if (ch == CH_QUOTE) begin
				mode_nxt = MODE_QUOTE;
			end else if (ch == CH_GT || ch == CH_AMP || ch == CH_BAR) begin
				k[n] = KIND_BYTE;
				n    = n + 2'd1;
				mode_nxt = (ch == CH_GT) ? MODE_GT : (ch == CH_AMP) ? MODE_AMP : MODE_BAR;
			end else if (ch == CH_LT || ch == CH_LPAR || ch == CH_RPAR ||
					ch == CH_SEMI) begin
				k[n]     = KIND_BYTE;
				k[n + 2'd1] = KIND_TOKEND;
				n        = n + 2'd2;
			end else begin
				k[n]     = KIND_BYTE;
				n        = n + 2'd1;
				mode_nxt = MODE_WORD;
			end
		end

		bnd.cnt      = n;
		bnd.kinds[0] = k[0];
		bnd.kinds[1] = k[1];
		bnd.kinds[2] = k[2];
		bnd.tok_byte = ch;
	end

	// Silent characters push nothing
	assign push      = accept && (bnd.cnt != 2'd0);
	assign push_data = bnd;

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
		end else if (accept) begin
			mode_q <= mode_nxt;
		end
	end

	`SCL_ASSERT_NXT(a_eoi_idle, accept && eoi, mode_q == MODE_IDLE,
		"end of input did not return lexer to idle")
	`SCL_ASSERT_IMP(a_eoi_push, accept && eoi, push,
		"end of input produced no result")

endmodule

// ===== rtl/core/scl_queue.sv =====
// Short queue of result bundles between the front and back parts.
`include "assert_macros.svh"
module scl_queue import scl_pkg::*; #(
	parameter int QueueDepth = SCL_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  bundle_t   push_data,
	input  logic      pop,
	output bundle_t   pop_data,
	output q_status_t q_stat
);

	localparam int PW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CW = $clog2(QueueDepth + 1);
	localparam logic [PW-1:0] LastPtr = PW'(QueueDepth - 1);
	localparam logic [CW-1:0] FullCnt = CW'(QueueDepth);

	bundle_t       mem_q [QueueDepth];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign q_stat.full     = (cnt_q == FullCnt);
	assign q_stat.nonempty = (cnt_q != '0);
	assign pop_data        = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`SCL_ASSERT_IMP(a_no_overflow, push && !pop, !q_stat.full, "push into full queue")
	`SCL_ASSERT_IMP(a_no_underflow, pop, q_stat.nonempty, "pop from empty queue")

endmodule

// ===== rtl/core/scl_back.sv =====
// Back part: issues the results of each bundle one transaction at a time.
`include "assert_macros.svh"
module scl_back import scl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_status_t q_stat,
	input  bundle_t   pop_data,
	output logic      pop,
	scl_chan_if.source res_ch
);

	logic       cur_valid_q;
	bundle_t    cur_q;
	logic [1:0] idx_q;
	logic       is_last;
	logic       take;
	kind_t      cur_kind;

	assign cur_kind = cur_q.kinds[idx_q];
	assign is_last  = (idx_q == cur_q.cnt - 2'd1);

	// Load a new bundle when empty or when the last result leaves
	assign take = !cur_valid_q || (res_ch.ready && is_last);
	assign pop  = take && q_stat.nonempty;

	// Result output
	assign res_ch.valid           = cur_valid_q;
	assign res_ch.data.kind       = cur_kind;
	assign res_ch.data.token_byte = (cur_kind == KIND_BYTE) ? cur_q.tok_byte : 8'h00;
	assign res_ch.data.last       = is_last;

	// Current bundle and result index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (take) begin
			cur_valid_q <= q_stat.nonempty;
			idx_q       <= 2'd0;
		end else if (res_ch.ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_data;
		end
	end

	`SCL_ASSERT_IMP(a_cnt_nonzero, cur_valid_q, cur_q.cnt != 2'd0, "empty bundle issued")
	`SCL_ASSERT_NXT(a_stall_idx, res_ch.valid && !res_ch.ready, $stable(idx_q),
		"result index moved under stall")

endmodule

// ===== rtl/core/shell_command_lexer_unit.sv =====
// Top level of the streaming shell command lexer.
//
//  channel  | dir | payload                         | accepted when
//  char_ch  | in  | char_in[7:0], end_of_input      | valid && ready
//  res_ch   | out | kind[2:0], token_byte[7:0], last| valid && ready
//
// One character is taken per cycle while the bundle queue has room.
// Each character yields zero to three results, issued one per cycle
// by the back part while the result side is ready.
// Front to first result: queue write, then bundle register.
// Reset clears lexer mode, queue pointers and the output valid.
// A stalled result side fills the queue; then char_ch.ready drops.
module shell_command_lexer_unit import scl_pkg::*; #(
	parameter int QueueDepth = SCL_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	scl_chan_if.sink   char_ch,
	scl_chan_if.source res_ch
);

	q_status_t q_stat;
	logic      push;
	logic      pop;
	bundle_t   push_data;
	bundle_t   pop_data;

	// Classifier
	scl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_ch   (char_ch),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	// Bundle queue
	scl_queue #(.QueueDepth(QueueDepth)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	// Result sequencer
	scl_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.pop_data (pop_data),
		.pop      (pop),
		.res_ch   (res_ch)
	);

endmodule

// ===== sim/shell_command_lexer_unit_test.sv =====
// Self-checking testbench of the streaming shell command lexer.
module shell_command_lexer_unit_test;
	import scl_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int RandomChars = 210;

	// Character waiting to be offered, with an optional drain before it
	typedef struct {
		in_item_t payload;
		bit       hold;
	} backlog_entry_t;

	logic clk;
	logic arst_n;

	scl_chan_if #(.T(in_item_t))  char_ch ();
	scl_chan_if #(.T(out_item_t)) res_ch ();

	shell_command_lexer_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.char_ch(char_ch),
		.res_ch (res_ch)
	);

	backlog_entry_t char_backlog[$];
	out_item_t      predicted_lexemes[$];
	out_item_t      step_lexemes[$];
	mode_t          lex_mode;

	string ops[10] = '{">", ">>", "&", "&&", "|", "||", "<", "(", ")", ";"};

	int  chars_queued;
	int  chars_accepted;
	int  lexemes_checked;
	int  mismatch_count;
	int  drain_pauses;
	int  stall_cycles;
	int  kind_seen[5];
	int  cycle_count;
	bit  hold_next;

	// Sender pacing
	int  gap_left;
	int  burst_left;
	bit  offer_busy;

	// Receiver pacing
	int  rx_style;
	int  rx_style_left;
	int  rx_stall_left;
	int  rx_phase;
	bit  rx_ready_next;

	// --------------------------------------------------------------
	// Lexer prediction
	// --------------------------------------------------------------
	function automatic bit word_char(logic [7:0] ch);
		return ch != CH_NL && ch != CH_SPACE && ch != CH_TAB && ch != CH_BAR &&
			ch != CH_AMP && ch != CH_SEMI && ch != CH_LT && ch != CH_GT &&
			ch != CH_LPAR && ch != CH_RPAR;
	endfunction

	function void note(kind_t k, logic [7:0] b);
		out_item_t r;
		r.kind = k;
		r.token_byte = (k == KIND_BYTE) ? b : 8'h00;
		r.last = 1'b0;
		step_lexemes.push_back(r);
	endfunction

	// Character seen between tokens
	function void idle_lex(logic [7:0] ch, logic eoi);
		lex_mode = MODE_IDLE;
		if (eoi) begin
			note(KIND_INEND, 8'h00);
		end else begin
			case (ch)
				CH_SPACE, CH_TAB: ;
				CH_NL: note(KIND_LINE, 8'h00);
				CH_QUOTE: lex_mode = MODE_QUOTE;
				CH_GT: begin
					note(KIND_BYTE, ch);
					lex_mode = MODE_GT;
				end
				CH_AMP: begin
					note(KIND_BYTE, ch);
					lex_mode = MODE_AMP;
				end
				CH_BAR: begin
					note(KIND_BYTE, ch);
					lex_mode = MODE_BAR;
				end
				CH_LT, CH_LPAR, CH_RPAR, CH_SEMI: begin
					note(KIND_BYTE, ch);
					note(KIND_TOKEND, 8'h00);
				end
				default: begin
					note(KIND_BYTE, ch);
					lex_mode = MODE_WORD;
				end
			endcase
		end
	endfunction

	// Expected results of one accepted character
	function void lex_step(in_item_t it);
		logic [7:0] dbl;
		logic [7:0] ch;
		logic       eoi;
		ch = it.char_in;
		eoi = it.end_of_input;
		step_lexemes.delete();
		case (lex_mode)
			MODE_WORD: begin
				if (!eoi && word_char(ch)) begin
					note(KIND_BYTE, ch);
				end else begin
					note(KIND_TOKEND, 8'h00);
					idle_lex(ch, eoi);
				end
			end
			MODE_GT, MODE_AMP, MODE_BAR: begin
				dbl = (lex_mode == MODE_GT) ? CH_GT : (lex_mode == MODE_AMP) ? CH_AMP : CH_BAR;
				if (!eoi && ch == dbl) begin
					note(KIND_BYTE, ch);
					note(KIND_TOKEND, 8'h00);
					lex_mode = MODE_IDLE;
				end else begin
					note(KIND_TOKEND, 8'h00);
					idle_lex(ch, eoi);
				end
			end
			MODE_QUOTE: begin
				if (eoi) begin
					note(KIND_ERROR, 8'h00);
					note(KIND_INEND, 8'h00);
					lex_mode = MODE_IDLE;
				end else if (ch == CH_NL) begin
					note(KIND_ERROR, 8'h00);
					note(KIND_LINE, 8'h00);
					lex_mode = MODE_IDLE;
				end else if (ch == CH_QUOTE) begin
					note(KIND_TOKEND, 8'h00);
					lex_mode = MODE_IDLE;
				end else begin
					note(KIND_BYTE, ch);
				end
			end
			default: idle_lex(ch, eoi);
		endcase
		if (step_lexemes.size() > 0)
			step_lexemes[step_lexemes.size() - 1].last = 1'b1;
		foreach (step_lexemes[i])
			predicted_lexemes.push_back(step_lexemes[i]);
	endfunction

	// --------------------------------------------------------------
	// Stimulus helpers
	// --------------------------------------------------------------
	function void queue_char(logic [7:0] c, logic e);
		backlog_entry_t ent;
		ent.payload.char_in = c;
		ent.payload.end_of_input = e;
		ent.hold = hold_next;
		hold_next = 1'b0;
		char_backlog.push_back(ent);
		chars_queued++;
	endfunction

	function void queue_text(string s);
		for (int i = 0; i < s.len(); i++)
			queue_char(s[i], 1'b0);
	endfunction

	function automatic logic [7:0] word_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (!word_char(b));
		return b;
	endfunction

	function automatic logic [7:0] quoted_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_NL || b == CH_QUOTE);
		return b;
	endfunction

	// --------------------------------------------------------------
	// Clock and time-zero input values
	// --------------------------------------------------------------
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		char_ch.valid = 1'b0;
		char_ch.data = '0;
		res_ch.ready = 1'b0;
		forever #1 clk = ~clk;
	end

	// --------------------------------------------------------------
	// Driver: offers backlog characters in bursts with gaps
	// --------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		backlog_entry_t nxt;
		if (!arst_n) begin
			char_ch.valid <= 1'b0;
			char_ch.data <= '0;
			gap_left = 0;
			burst_left = 1;
			lex_mode = MODE_IDLE;
		end else begin
			offer_busy = char_ch.valid;
			if (char_ch.valid && char_ch.ready) begin
				lex_step(char_ch.data);
				chars_accepted++;
				offer_busy = 1'b0;
			end
			if (!offer_busy) begin
				if (gap_left > 0) begin
					gap_left--;
					char_ch.valid <= 1'b0;
				end else if (char_backlog.size() == 0 ||
						(char_backlog[0].hold && predicted_lexemes.size() != 0)) begin
					char_ch.valid <= 1'b0;
				end else begin
					nxt = char_backlog.pop_front();
					if (nxt.hold)
						drain_pauses++;
					char_ch.data <= nxt.payload;
					char_ch.valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	// --------------------------------------------------------------
	// Monitor: checks each result transaction, paces ready
	// --------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			rx_style = 0;
			rx_style_left = 0;
			rx_stall_left = 0;
			rx_phase = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				lexemes_checked++;
				if (res_ch.data.kind <= KIND_INEND)
					kind_seen[res_ch.data.kind]++;
				if (predicted_lexemes.size() == 0) begin
					$error("unexpected result: kind %0d byte %0h last %0b",
						res_ch.data.kind, res_ch.data.token_byte, res_ch.data.last);
					mismatch_count++;
				end else begin
					want = predicted_lexemes.pop_front();
					if (res_ch.data.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, res_ch.data.kind);
						mismatch_count++;
					end
					if (res_ch.data.token_byte !== want.token_byte) begin
						$error("token_byte: expected %0h, got %0h",
							want.token_byte, res_ch.data.token_byte);
						mismatch_count++;
					end
					if (res_ch.data.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, res_ch.data.last);
						mismatch_count++;
					end
				end
			end

			// ready pattern: full speed, coin flip, one in three, long stalls
			if (rx_style_left == 0) begin
				rx_style = $urandom_range(0, 3);
				rx_style_left = $urandom_range(20, 80);
			end else begin
				rx_style_left--;
			end
			rx_phase++;
			case (rx_style)
				0: rx_ready_next = 1'b1;
				1: rx_ready_next = 1'($urandom_range(0, 1));
				2: rx_ready_next = (rx_phase % 3 == 0);
				default: begin
					if (rx_stall_left > 0) begin
						rx_stall_left--;
						rx_ready_next = 1'b0;
					end else if ($urandom_range(0, 7) == 0) begin
						rx_stall_left = $urandom_range(4, 15);
						rx_ready_next = 1'b0;
					end else begin
						rx_ready_next = 1'b1;
					end
				end
			endcase
			if (!rx_ready_next)
				stall_cycles++;
			res_ch.ready <= rx_ready_next;
		end
	end

	// --------------------------------------------------------------
	// Watchdog
	// --------------------------------------------------------------
	initial begin
		cycle_count = 0;
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding",
			cycle_count, predicted_lexemes.size());
		$display("simulation failed");
		$finish;
	end

	// --------------------------------------------------------------
	// Stimulus and end of run
	// --------------------------------------------------------------
	initial begin
		int pick;
		int n;
		hold_next = 1'b0;

		// Directed: odd word bytes, doubled and single operators,
		// empty and normal quotes, unterminated quotes, end inside tokens
		queue_char(8'h00, 1'b0);
		queue_char(CH_QUOTE, 1'b0);
		queue_char(8'hFF, 1'b0);
		queue_text(" >>>&&&|||");
		queue_text("<();");
		queue_text("\"\"\t\"a\"\n");
		queue_text("\"q\n");
		queue_char(CH_QUOTE, 1'b0);
		queue_char(8'hA5, 1'b1);
		queue_char(CH_BAR, 1'b0);
		queue_char(8'h5A, 1'b1);
		hold_next = 1'b1;

		// Random: mostly well-formed tokens, some noise, up to the item budget
		while (chars_queued < RandomChars) begin
			if ($urandom_range(0, 39) == 0)
				hold_next = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				n = $urandom_range(1, 6);
				repeat (n) queue_char(word_byte(), 1'b0);
			end else if (pick < 55) begin
				queue_text(ops[$urandom_range(0, 9)]);
			end else if (pick < 67) begin
				queue_char(CH_QUOTE, 1'b0);
				n = $urandom_range(0, 5);
				repeat (n) queue_char(quoted_byte(), 1'b0);
				queue_char(CH_QUOTE, 1'b0);
			end else if (pick < 75) begin
				queue_char(CH_NL, 1'b0);
			end else if (pick < 87) begin
				queue_char(8'($urandom_range(0, 255)), 1'b0);
			end else if (pick < 92) begin
				queue_char(CH_QUOTE, 1'b0);
				queue_char(quoted_byte(), 1'b0);
				if ($urandom_range(0, 1))
					queue_char(CH_NL, 1'b0);
				else
					queue_char(8'($urandom_range(0, 255)), 1'b1);
			end else begin
				queue_char(8'($urandom_range(0, 255)), 1'b1);
			end
			// separator, often left out so tokens abut
			if ($urandom_range(0, 2) != 0) begin
				n = $urandom_range(1, 2);
				repeat (n) queue_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
			end
		end
		queue_char(8'h00, 1'b1);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (chars_accepted == chars_queued);
		wait (predicted_lexemes.size() == 0);
		repeat (10) @(posedge clk);
		if (predicted_lexemes.size() != 0) begin
			$error("%0d expected results never arrived", predicted_lexemes.size());
			mismatch_count++;
		end

		$display("%0d characters sent, %0d results checked: %0d bytes, %0d token ends,",
			chars_accepted, lexemes_checked, kind_seen[KIND_BYTE], kind_seen[KIND_TOKEND]);
		$display("%0d line ends, %0d quote errors, %0d input ends; %0d drains, %0d stalls",
			kind_seen[KIND_LINE], kind_seen[KIND_ERROR], kind_seen[KIND_INEND],
			drain_pauses, stall_cycles);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
